### rtl/fpgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpgb_pkg
// Shared types and constants of the fuzzy PID gain table blend.
// ----------------------------------------------------------------------------
package fpgb_pkg;

  localparam int VW        = 16;          // value width
  localparam int IN_W      = 104;         // input tdata width
  localparam int OUT_W     = 48;          // output tdata width
  localparam int FULL      = 100;         // full weight
  localparam int WW        = 7;           // weight width
  localparam int ACC_W     = 30;          // blended sum width
  localparam int QBITS     = ACC_W - 1;   // magnitude bits of a sum
  localparam int DIV_STEPS = WW;
  localparam int QSHIFT    = 35;          // reciprocal scale of 1/100

  // ceil(2^35 / 100); exact quotient for magnitudes below 2^29
  localparam logic [QBITS-1:0] RECIP = 29'd343597384;

  localparam logic [1:0] REQ_ERR_PT  = 2'd0;
  localparam logic [1:0] REQ_RATE_PT = 2'd1;
  localparam logic [1:0] REQ_CELL    = 2'd2;
  localparam logic [1:0] REQ_EVAL    = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       scan_step;
    logic       wsetup;
    logic       div_start;
    logic       div_step;
    logic       div_store;
    logic [1:0] dsel;
    logic       term_addr;
    logic       term_mul;
    logic       term_acc;
    logic [1:0] term;
    logic       q_init;
    logic       q_step;
    logic       res_load;
    logic       res_zero;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic zero_cnt;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/fuzzy_pid_gain_table_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_table_blend
// Fuzzy PID gain scheduling by bilinear blend of P, I and D gain tables.
// Load transfers: the result is an acknowledge, all zero; an evaluate with a zero
// row or column count returns all zero too. Evaluate: scan, four 7-step divisions,
// four cell reads, 1/100 multiply.
// One item at a time; the next is taken the cycle after its result loads, even
// while that result waits; a result still waiting holds the item in its last step.
// Synchronous reset: counts return to 7; tables are undefined until written.
// ----------------------------------------------------------------------------
module fuzzy_pid_gain_table_blend
  import fpgb_pkg::*;
#(
  parameter int MAX_ROWS = 10,
  parameter int MAX_COLS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // row_index, col_index, point_value, p_entry, i_entry, d_entry,
  // error_value, error_rate
  input  wire logic [IN_W-1:0]   s_tdata,
  // req_type
  input  wire logic [1:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // p_gain, i_gain, d_gain
  output logic [OUT_W-1:0]       m_tdata,
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic [3:0]        wr_data
);

  cmd_t cmd;
  sts_t sts;

  fpgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpgb_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

### rtl/fpgb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpgb_ctrl
// Sequencer: search, weight divisions, term accumulation, scaling, result.
// ----------------------------------------------------------------------------
module fpgb_ctrl
  import fpgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic [1:0] s_tuser,
  output logic            s_tready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [3:0] {
    IDLE, SCAN, WSET, DLOAD, DSTEP, DSTORE, TADDR, TMUL, TACC, QINIT, QSTEP, FIN
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic [1:0] dsel;
  logic [1:0] term;
  logic       zero;
  logic       accept;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      dsel  <= '0;
      term  <= '0;
      zero  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            if (s_tuser != REQ_EVAL || sts.zero_cnt) begin
              zero  <= 1'b1;
              state <= FIN;
            end else begin
              zero  <= 1'b0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (sts.scan_done) state <= WSET;
        end
        WSET: begin
          dsel  <= '0;
          state <= DLOAD;
        end
        DLOAD: begin
          cnt   <= '0;
          state <= DSTEP;
        end
        DSTEP: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) state <= DSTORE;
        end
        DSTORE: begin
          dsel <= dsel + 2'd1;
          if (dsel == 2'd3) begin
            term  <= '0;
            state <= TADDR;
          end else begin
            state <= DLOAD;
          end
        end
        TADDR: state <= TMUL;
        TMUL:  state <= TACC;
        TACC: begin
          term <= term + 2'd1;
          state <= (term == 2'd3) ? QINIT : TADDR;
        end
        QINIT: state <= QSTEP;
        QSTEP: state <= FIN;
        FIN: begin
          if (sts.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.scan_step = (state == SCAN);
    cmd.wsetup    = (state == WSET);
    cmd.div_start = (state == DLOAD);
    cmd.div_step  = (state == DSTEP);
    cmd.div_store = (state == DSTORE);
    cmd.dsel      = dsel;
    cmd.term_addr = (state == TADDR);
    cmd.term_mul  = (state == TMUL);
    cmd.term_acc  = (state == TACC);
    cmd.term      = term;
    cmd.q_init    = (state == QINIT);
    cmd.q_step    = (state == QSTEP);
    cmd.res_load  = (state == FIN) && sts.out_free;
    cmd.res_zero  = zero;
  end

endmodule

`default_nettype wire

### rtl/fpgb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpgb_datapath
// Breakpoints, cell memory, search, weight divider, MACs, scale-by-1/100 multiply.
// ----------------------------------------------------------------------------
module fpgb_datapath
  import fpgb_pkg::*;
#(
  parameter int MAX_ROWS = 10,
  parameter int MAX_COLS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IN_W-1:0]   s_tdata,
  input  wire logic [1:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic [3:0]        wr_data,
  input  wire cmd_t              cmd,
  output sts_t                   sts
);

  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CAW   = $clog2(CELLS);

  // input fields
  logic [3:0]             in_row, in_col;
  logic signed [VW-1:0]   in_point, in_err, in_rate;
  logic [3*VW-1:0]        in_cell;
  assign in_row   = s_tdata[3:0];
  assign in_col   = s_tdata[7:4];
  assign in_point = s_tdata[23:8];
  assign in_cell  = s_tdata[71:24];
  assign in_err   = s_tdata[87:72];
  assign in_rate  = s_tdata[103:88];

  logic row_ok, col_ok;
  assign row_ok = {1'b0, in_row} < 5'(MAX_ROWS);
  assign col_ok = {1'b0, in_col} < 5'(MAX_COLS);

  // configuration
  logic [3:0] row_count, col_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 4'd7;
      col_count <= 4'd7;
    end else if (wr_en) begin
      if (wr_index == CFG_ROWS) row_count <= wr_data;
      if (wr_index == CFG_COLS) col_count <= wr_data;
    end
  end

  logic [4:0] nr, nc;
  assign nr = ({1'b0, row_count} > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : {1'b0, row_count};
  assign nc = ({1'b0, col_count} > 5'(MAX_COLS)) ? 5'(MAX_COLS) : {1'b0, col_count};

  // breakpoints and cells
  logic signed [VW-1:0] epts [MAX_ROWS];
  logic signed [VW-1:0] rpts [MAX_COLS];
  logic [3*VW-1:0]      cells [CELLS];
  logic [3*VW-1:0]      rdata;
  logic [CAW-1:0]       raddr, waddr;

  assign waddr = CAW'(in_row) * CAW'(MAX_COLS) + CAW'(in_col);

  always_ff @(posedge clk) begin
    if (cmd.accept && s_tuser == REQ_ERR_PT && row_ok) epts[in_row[RIW-1:0]] <= in_point;
    if (cmd.accept && s_tuser == REQ_RATE_PT && col_ok) rpts[in_col[CIW-1:0]] <= in_point;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && s_tuser == REQ_CELL && row_ok && col_ok) cells[waddr] <= in_cell;
    if (cmd.term_addr) rdata <= cells[raddr];
  end

  // search
  logic signed [VW-1:0] ev, rv, prev_r, prev_c;
  logic [4:0]           kr, kc;
  logic                 dr, dc;
  logic signed [VW-1:0] cur_r, cur_c;
  assign cur_r = epts[kr[RIW-1:0]];
  assign cur_c = rpts[kc[CIW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ev <= in_err;
      rv <= in_rate;
      kr <= '0;
      kc <= '0;
      dr <= 1'b0;
      dc <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!dr) begin
        if (kr == nr || ev <= cur_r) dr <= 1'b1;
        else begin
          prev_r <= cur_r;
          kr     <= kr + 5'd1;
        end
      end
      if (!dc) begin
        if (kc == nc || rv <= cur_c) dc <= 1'b1;
        else begin
          prev_c <= cur_c;
          kc     <= kc + 5'd1;
        end
      end
    end
  end

  // weight setup
  logic [3:0]    ra, rb, ca, cb;
  logic [VW-1:0] na_r, nb_r, sp_r, na_c, nb_c, sp_c;
  logic [WW-1:0] wra, wrb, wca, wcb;

  always_ff @(posedge clk) begin
    if (cmd.wsetup) begin
      if (kr == 5'd0 || kr == nr) begin
        ra   <= (kr == 5'd0) ? 4'd0 : 4'(nr - 5'd1);
        rb   <= (kr == 5'd0) ? 4'd0 : 4'(nr - 5'd1);
        na_r <= VW'(1);
        nb_r <= '0;
        sp_r <= VW'(1);
      end else begin
        ra   <= kr[3:0];
        rb   <= 4'(kr - 5'd1);
        na_r <= VW'(ev - prev_r);
        nb_r <= VW'(cur_r - ev);
        sp_r <= VW'(cur_r - prev_r);
      end
      if (kc == 5'd0 || kc == nc) begin
        ca   <= (kc == 5'd0) ? 4'd0 : 4'(nc - 5'd1);
        cb   <= (kc == 5'd0) ? 4'd0 : 4'(nc - 5'd1);
        na_c <= VW'(1);
        nb_c <= '0;
        sp_c <= VW'(1);
      end else begin
        ca   <= kc[3:0];
        cb   <= 4'(kc - 5'd1);
        na_c <= VW'(rv - prev_c);
        nb_c <= VW'(cur_c - rv);
        sp_c <= VW'(cur_c - prev_c);
      end
    end
  end

  // weight divider: 100*n / span, quotient below 128
  logic [22:0]   drem;
  logic [21:0]   dsh;
  logic [WW-1:0] dq;
  logic [VW-1:0] dnum, dden;

  always_comb begin
    case (cmd.dsel)
      2'd0:    begin dnum = na_r; dden = sp_r; end
      2'd1:    begin dnum = nb_r; dden = sp_r; end
      2'd2:    begin dnum = na_c; dden = sp_c; end
      default: begin dnum = nb_c; dden = sp_c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem <= 23'(dnum) * 23'(FULL);
      dsh  <= {dden, 6'b0};
      dq   <= '0;
    end else if (cmd.div_step) begin
      if ({1'b0, dsh} <= drem) begin
        drem <= drem - {1'b0, dsh};
        dq   <= {dq[WW-2:0], 1'b1};
      end else begin
        dq   <= {dq[WW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.div_store) begin
      case (cmd.dsel)
        2'd0:    wra <= dq;
        2'd1:    wrb <= dq;
        2'd2:    wca <= dq;
        default: wcb <= dq;
      endcase
    end
  end

  // term accumulation
  logic [3:0]             ti_r, ti_c;
  logic [WW-1:0]          tw_r, tw_c;
  logic [2*WW-1:0]        wp;
  logic signed [ACC_W-1:0] prod [3];
  logic signed [ACC_W-1:0] acc  [3];

  assign ti_r  = cmd.term[1] ? rb : ra;
  assign tw_r  = cmd.term[1] ? wrb : wra;
  assign ti_c  = cmd.term[0] ? cb : ca;
  assign tw_c  = cmd.term[0] ? wcb : wca;
  assign raddr = CAW'(ti_r) * CAW'(MAX_COLS) + CAW'(ti_c);

  always_ff @(posedge clk) begin
    if (cmd.term_addr) wp <= tw_r * tw_c;
    for (int g = 0; g < 3; g++) begin
      if (cmd.wsetup) acc[g] <= '0;
      if (cmd.term_mul)
        prod[g] <= ACC_W'($signed({1'b0, wp})) * ACC_W'($signed(rdata[g*VW +: VW]));
      if (cmd.term_acc) acc[g] <= acc[g] + prod[g];
    end
  end

  // scale by 1/100: magnitude times the reciprocal, then a shift
  logic               neg   [3];
  logic [QBITS-1:0]   sh    [3];
  logic [2*QBITS-1:0] qprod [3];
  logic [VW-1:0]      qq    [3];

  always_comb begin
    for (int g = 0; g < 3; g++) qq[g] = qprod[g][QSHIFT +: VW];
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      if (cmd.q_init) begin
        neg[g] <= acc[g][ACC_W-1];
        sh[g]  <= acc[g][ACC_W-1] ? QBITS'(-acc[g]) : QBITS'(acc[g]);
      end
      if (cmd.q_step) qprod[g] <= (2*QBITS)'(sh[g]) * (2*QBITS)'(RECIP);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.res_zero) m_tdata <= '0;
      else begin
        for (int g = 0; g < 3; g++)
          m_tdata[g*VW +: VW] <= neg[g] ? VW'(-qq[g]) : qq[g];
      end
    end
  end

  assign sts.scan_done = dr && dc;
  assign sts.zero_cnt  = (nr == 5'd0) || (nc == 5'd0);
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

### dv/fuzzy_pid_gain_table_blend_tb.sv
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_table_blend_tb
// Self-checking bench for the gain table blend. The bench loads breakpoints
// and P/I/D tables, then sends evaluate transfers under several row and
// column counts. A scoreboard keeps its own copy of the tables, predicts each
// blended gain and checks every output transfer in order. Both sides idle at
// random, and one phase holds off the output for a long stretch.
// ----------------------------------------------------------------------------
module fuzzy_pid_gain_table_blend_tb;
  import fpgb_pkg::*;

  localparam int NR = 10;
  localparam int NC = 10;
  localparam int LIMIT = 2000000;

  class gain_scoreboard;
    int rows, cols;
    int err_pt[NR];
    int rate_pt[NC];
    int pc[NR*NC];
    int ic[NR*NC];
    int dc[NR*NC];
    logic [OUT_W-1:0] pending[$];
    int errors;

    function new();
      rows = 7;
      cols = 7;
      errors = 0;
    endfunction

    function void axis(input int b[], input int cnt, input int v, ref int w[]);
      int k, span;
      k = 0;
      while (k < cnt && v > b[k]) k++;
      if (k == 0) begin
        w[0] = FULL;
      end else if (k == cnt) begin
        w[cnt-1] = FULL;
      end else begin
        span = b[k] - b[k-1];
        w[k] = (FULL * (v - b[k-1])) / span;
        w[k-1] = (FULL * (b[k] - v)) / span;
      end
    endfunction

    function void note_input(input logic [1:0] req, input logic [IN_W-1:0] d);
      int row, col, nr, nc;
      int rw[], cw[];
      int eb[], rb[];
      longint ps, is, ds, wt;
      logic [15:0] pg, ig, dg;
      row = int'(d[3:0]);
      col = int'(d[7:4]);
      pg = 0; ig = 0; dg = 0;
      case (req)
        REQ_ERR_PT: begin
          if (row < NR) err_pt[row] = int'($signed(d[23:8]));
        end
        REQ_RATE_PT: begin
          if (col < NC) rate_pt[col] = int'($signed(d[23:8]));
        end
        REQ_CELL: begin
          if (row < NR && col < NC) begin
            pc[row*NC+col] = int'($signed(d[39:24]));
            ic[row*NC+col] = int'($signed(d[55:40]));
            dc[row*NC+col] = int'($signed(d[71:56]));
          end
        end
        default: begin
          nr = rows > NR ? NR : rows;
          nc = cols > NC ? NC : cols;
          rw = new[NR];
          cw = new[NC];
          eb = err_pt;
          rb = rate_pt;
          ps = 0; is = 0; ds = 0;
          if (nr > 0) axis(eb, nr, int'($signed(d[87:72])), rw);
          if (nc > 0) axis(rb, nc, int'($signed(d[103:88])), cw);
          for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
              wt = longint'(rw[r]) * longint'(cw[c]);
              ps += wt * longint'(pc[r*NC+c]);
              is += wt * longint'(ic[r*NC+c]);
              ds += wt * longint'(dc[r*NC+c]);
            end
          pg = 16'(ps / FULL);
          ig = 16'(is / FULL);
          dg = 16'(ds / FULL);
        end
      endcase
      pending.push_back({dg, ig, pg});
    endfunction

    function void check_result(input logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      for (int f = 0; f < 3; f++)
        if (got[f*16 +: 16] !== exp[f*16 +: 16]) begin
          $display("%0t: gain %0d expected %h actual %h", $time, f,
                   exp[f*16 +: 16], got[f*16 +: 16]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [IN_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic wr_en, wr_index;
  logic [3:0] wr_data;

  gain_scoreboard sb;
  int cycles;
  bit hold_off;
  bit sending_done;

  fuzzy_pid_gain_table_blend dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("fuzzy_pid_gain_table_blend_tb failed");
        $finish;
      end
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_off) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap == 0) m_tready <= 1;
      else begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
        m_tready <= 1;
      end
    end
  end

  bit burst;

  task automatic send(input logic [1:0] req, input logic [IN_W-1:0] d);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= req;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_input(req, d);
  endtask

  function automatic logic [IN_W-1:0] pack(input int row, input int col,
      input int pt, input int p, input int i,
      input int d, input int e, input int r);
    return {16'(r), 16'(e), 16'(d), 16'(i), 16'(p), 16'(pt), col[3:0], row[3:0]};
  endfunction

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_counts(input int r, input int c);
    drain();
    wr_en <= 1; wr_index <= CFG_ROWS; wr_data <= 4'(r);
    @(posedge clk);
    wr_index <= CFG_COLS; wr_data <= 4'(c);
    @(posedge clk);
    wr_en <= 0;
    sb.rows = r;
    sb.cols = c;
  endtask

  function automatic int rnd16();
    case ($urandom_range(0, 5))
      0: return 32'h8000;
      1: return 32'h7fff;
      2: return 32'hffff;
      default: return int'($urandom);
    endcase
  endfunction

  // ascending breakpoints over a fixed extreme spread or a random range, then all cells
  task automatic load_tables(input bit extreme);
    int base, stepv;
    for (int a = 0; a < 2; a++) begin
      base = extreme ? -32768 : $urandom_range(0, 20000) - 30000;
      for (int k = 0; k < 10; k++) begin
        stepv = extreme ? 7281 : $urandom_range(1, 5000);
        if (a == 0) send(REQ_ERR_PT, pack(k, $urandom_range(0, 15), base, $urandom,
          $urandom, $urandom, $urandom, $urandom));
        else send(REQ_RATE_PT, pack($urandom_range(0, 15), k, base, $urandom,
          $urandom, $urandom, $urandom, $urandom));
        base = (base + stepv > 32767) ? 32767 : base + stepv;
      end
    end
    for (int r = 0; r < 10; r++)
      for (int c = 0; c < 10; c++)
        send(REQ_CELL, pack(r, c, $urandom, rnd16(), rnd16(), rnd16(), $urandom, $urandom));
  endtask

  task automatic evaluate(input int e, input int r);
    send(REQ_EVAL, pack($urandom_range(0, 15), $urandom_range(0, 15), $urandom,
      $urandom, $urandom, $urandom, e, r));
  endtask

  function automatic int near(input int k, input bit rate);
    int v;
    v = (rate ? sb.rate_pt[k] : sb.err_pt[k]) + $urandom_range(0, 4000) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    int settings[6][2] = '{'{7, 7}, '{1, 1}, '{10, 10}, '{15, 0}, '{0, 12}, '{3, 9}};
    sb = new();
    rst = 1; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    wr_en = 0; wr_index = 0; wr_data = 0;
    hold_off = 0; burst = 0; sending_done = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    load_tables(1);
    // directed: extremes, exact breakpoints, out-of-range writes
    evaluate(32'h8000, 32'h8000);
    evaluate(32'h7fff, 32'h7fff);
    evaluate(sb.err_pt[3], sb.rate_pt[4]);
    evaluate(0, 32'hffff);
    send(REQ_ERR_PT, pack(15, 0, 32'h1234, 0, 0, 0, 0, 0));
    send(REQ_RATE_PT, pack(0, 12, 32'h1234, 0, 0, 0, 0, 0));
    send(REQ_CELL, pack(10, 3, 0, 32'h7fff, 32'h8000, 1, 0, 0));
    send(REQ_CELL, pack(2, 15, 0, 32'h7fff, 32'h8000, 1, 0, 0));
    evaluate(32'h7fff, 32'h8000);

    for (int s = 0; s < 6; s++) begin
      set_counts(settings[s][0], settings[s][1]);
      if (s == 2) load_tables(0);
      if (s == 3) begin
        hold_off = 1;
        burst = 1;
      end
      for (int n = 0; n < 40; n++) begin
        if (n == 20) burst = 0;
        case ($urandom_range(0, 9))
          0: evaluate($urandom, $urandom);
          1: send(REQ_CELL, pack($urandom_range(0, 15), $urandom_range(0, 15), $urandom,
               rnd16(), rnd16(), rnd16(), $urandom, $urandom));
          default: evaluate(near($urandom_range(0, 9), 0), near($urandom_range(0, 9), 1));
        endcase
      end
    end

    // breakpoints rewritten out of order
    set_counts(10, 10);
    for (int k = 0; k < 10; k++) begin
      send(REQ_ERR_PT, pack(k, 0, $urandom, 0, 0, 0, 0, 0));
      send(REQ_RATE_PT, pack(0, k, $urandom, 0, 0, 0, 0, 0));
    end
    for (int n = 0; n < 40; n++) evaluate($urandom, $urandom);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("fuzzy_pid_gain_table_blend_tb passed");
    else
      $display("fuzzy_pid_gain_table_blend_tb failed");
    $finish;
  end
endmodule
